>>> rtl/core/binary_min_heap_queue_defines.svh
// Assertion macros shared by the heap queue RTL.
// Each macro checks a property on the rising clock edge, outside of reset.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define BMHQ_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BMHQ_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BMHQ_ASSERT_IMP(name, ante, cons, msg)
`define BMHQ_ASSERT_NXT(name, ante, cons, msg)
`endif
`endif

>>> rtl/core/bmhq_pkg.sv
`default_nettype none
package bmhq_pkg;

  // Default sizing of the queue.
  localparam int unsigned CapacityDef    = 1024;
  localparam int unsigned KeyWidthDef    = 32;
  localparam int unsigned HandleWidthDef = 16;

  // Request type codes.
  localparam logic REQ_INSERT  = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  // Result status codes.
  localparam int unsigned StatusW = 2;
  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  // Read address select for the entry store.
  typedef enum logic [1:0] {
    RD_PARENT,
    RD_LAST,
    RD_LEFT,
    RD_RIGHT
  } rd_sel_e;

  // Write data select for the entry store.
  typedef enum logic [1:0] {
    WR_ITEM,
    WR_PARENT,
    WR_PICK
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                accept_ins;
    logic                accept_ext;
    logic                rd_en;
    rd_sel_e             rd_sel;
    logic                wr_en;
    wr_sel_e             wr_sel;
    logic                load_item;
    logic                cap_left;
    logic                finish;
    logic [StatusW-1:0]  status;
  } bmhq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic one;
    logic hole_zero;
    logic parent_gt;
    logic has_left;
    logic item_le_pick;
  } bmhq_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/binary_min_heap_queue.sv
// Binary min-heap priority queue of (key, handle) entries.
// Request channel: drive req_type_i, key_i and handle_i with start high; the
// beat is taken at a rising edge where busy is low. req_type_i 0 inserts the
// entry, 1 extracts the entry with the smallest key.
// Result channel: done_o is high for exactly one cycle per request and the
// result ports hold the beat in that cycle; the receiver cannot stall it.
// Each result carries the extracted entry (zero otherwise), a status code,
// the entry count, an empty flag and the current minimum key.
// Refused requests and extracts that leave the heap empty finish from the
// idle state with no further state. An insert climbs one level per read and
// compare, from ST_INS_RD to ST_INS_CMP; an extract fetches the last entry
// (ST_EXT_LAST, ST_EXT_LOAD) and then sinks it one level per pass through
// ST_SD_RDL, ST_SD_RDR and ST_SD_CMP. The single registered read port of the
// entry RAM sets this pace: each level needs a read round trip before its
// compare.
// A new request may be taken in the cycle done_o is high.
// Reset empties the heap at once; the entry RAM is not cleared, since a slot's
// contents are only used once it holds a written entry.
`default_nettype none
`include "binary_min_heap_queue_defines.svh"
module binary_min_heap_queue import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY     = CapacityDef,
  parameter int unsigned KEY_WIDTH    = KeyWidthDef,
  parameter int unsigned HANDLE_WIDTH = HandleWidthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       req_type_i,
  input  wire logic [KEY_WIDTH-1:0]       key_i,
  input  wire logic [HANDLE_WIDTH-1:0]    handle_i,
  output logic                            done_o,
  output logic [HANDLE_WIDTH-1:0]         out_handle_o,
  output logic [KEY_WIDTH-1:0]            out_key_o,
  output logic [StatusW-1:0]              status_o,
  output logic [$clog2(CAPACITY+1)-1:0]   entry_count_o,
  output logic                            is_empty_o,
  output logic [KEY_WIDTH-1:0]            min_key_o
);

  localparam int unsigned CntW = $clog2(CAPACITY+1);

  bmhq_cmd_t  cmd;
  bmhq_stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .busy       (busy),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  bmhq_datapath #(
    .CAPACITY     (CAPACITY),
    .KEY_WIDTH    (KEY_WIDTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .key_i         (key_i),
    .handle_i      (handle_i),
    .done_o        (done_o),
    .out_handle_o  (out_handle_o),
    .out_key_o     (out_key_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .min_key_o     (min_key_o)
  );

  // A result beat always lands while the controller is back at rest.
  `BMHQ_ASSERT_IMP(a_done_idle, done_o, !busy, "result beat while busy")
  // An accepted request either keeps the block busy or finishes at once.
  `BMHQ_ASSERT_NXT(a_accept_progress, start && !busy, busy || done_o, "request lost")
  // A refused insert only happens on a full heap.
  `BMHQ_ASSERT_IMP(a_full_count, done_o && (status_o == STATUS_FULL),
                   entry_count_o == CntW'(CAPACITY), "full status with room left")
  // An extract on an empty heap reports an empty heap and no entry.
  `BMHQ_ASSERT_IMP(a_empty_result, done_o && (status_o == STATUS_EMPTY),
                   is_empty_o && (out_key_o == '0), "bad empty extract result")

endmodule
`default_nettype wire

>>> rtl/core/bmhq_ram.sv
`default_nettype none
module bmhq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bmhq_datapath.sv
`default_nettype none
module bmhq_datapath import bmhq_pkg::*; #(
  parameter int unsigned CAPACITY     = CapacityDef,
  parameter int unsigned KEY_WIDTH    = KeyWidthDef,
  parameter int unsigned HANDLE_WIDTH = HandleWidthDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire bmhq_cmd_t                        cmd_i,
  output bmhq_stat_t                            stat_o,
  input  wire logic [KEY_WIDTH-1:0]             key_i,
  input  wire logic [HANDLE_WIDTH-1:0]          handle_i,
  output logic                                  done_o,
  output logic [HANDLE_WIDTH-1:0]               out_handle_o,
  output logic [KEY_WIDTH-1:0]                  out_key_o,
  output logic [StatusW-1:0]                    status_o,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count_o,
  output logic                                  is_empty_o,
  output logic [KEY_WIDTH-1:0]                  min_key_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY+1);
  localparam int unsigned ChW  = IdxW + 2;
  localparam int unsigned EntW = KEY_WIDTH + HANDLE_WIDTH;

  logic [CntW-1:0]  count_q, count_d;
  logic             done_q;
  logic [StatusW-1:0] status_q;
  logic [IdxW-1:0]  hole_q;
  logic [EntW-1:0]  item_q, left_q, root_q, out_q;
  logic             right_valid_q;

  logic [EntW-1:0]  rdata;
  logic [EntW-1:0]  wdata;
  logic [EntW-1:0]  pick;
  logic [IdxW-1:0]  raddr;
  logic [IdxW-1:0]  parent_idx;
  logic [ChW-1:0]   left_w, right_w, count_w;
  logic             pick_right;

  // Child and parent slot indices of the hole.
  assign parent_idx = IdxW'((hole_q - IdxW'(1)) >> 1);
  assign left_w     = {1'b0, hole_q, 1'b1};
  assign right_w    = {1'b0, hole_q, 1'b0} + ChW'(2);
  assign count_w    = ChW'(count_q);

  // The right child wins only when it is strictly smaller than the left one.
  assign pick_right = right_valid_q &&
                      (rdata[EntW-1:HANDLE_WIDTH] < left_q[EntW-1:HANDLE_WIDTH]);
  assign pick       = pick_right ? rdata : left_q;

  // Read address mux.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_PARENT: raddr = parent_idx;
      RD_LAST:   raddr = count_q[IdxW-1:0];
      RD_LEFT:   raddr = left_w[IdxW-1:0];
      RD_RIGHT:  raddr = right_w[IdxW-1:0];
      default:   raddr = parent_idx;
    endcase
  end

  // Write data mux; the write always goes to the hole.
  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_ITEM:   wdata = item_q;
      WR_PARENT: wdata = rdata;
      WR_PICK:   wdata = pick;
      default:   wdata = item_q;
    endcase
  end

  bmhq_ram #(
    .WIDTH (EntW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (hole_q),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Entry count update.
  always_comb begin
    count_d = count_q;
    if (cmd_i.accept_ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.accept_ext) begin
      count_d = count_q - CntW'(1);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_OK;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.finish;
      if (cmd_i.finish) begin
        status_q <= cmd_i.status;
      end
    end
  end

  // Hole, moving entry and the cached root.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_ins) begin
      hole_q <= count_q[IdxW-1:0];
      item_q <= {key_i, handle_i};
    end
    if (cmd_i.load_item) begin
      item_q <= rdata;
      hole_q <= '0;
    end
    if (cmd_i.wr_en && (cmd_i.wr_sel == WR_PARENT)) begin
      hole_q <= parent_idx;
    end
    if (cmd_i.wr_en && (cmd_i.wr_sel == WR_PICK)) begin
      hole_q <= pick_right ? right_w[IdxW-1:0] : left_w[IdxW-1:0];
    end
    if (cmd_i.rd_en && (cmd_i.rd_sel == RD_LEFT)) begin
      right_valid_q <= (right_w < count_w);
    end
    if (cmd_i.cap_left) begin
      left_q <= rdata;
    end
    if (cmd_i.wr_en && (hole_q == '0)) begin
      root_q <= wdata;
    end
  end

  // Extracted entry; zero on inserts and on refused requests.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept_ins) begin
      out_q <= '0;
    end else if (cmd_i.accept_ext) begin
      out_q <= root_q;
    end else if (cmd_i.finish && (cmd_i.status != STATUS_OK)) begin
      out_q <= '0;
    end
  end

  // Status toward the controller.
  assign stat_o.full         = (count_q == CntW'(CAPACITY));
  assign stat_o.empty        = (count_q == '0);
  assign stat_o.one          = (count_q == CntW'(1));
  assign stat_o.hole_zero    = (hole_q == '0);
  assign stat_o.parent_gt    = (rdata[EntW-1:HANDLE_WIDTH] > item_q[EntW-1:HANDLE_WIDTH]);
  assign stat_o.has_left     = (left_w < count_w);
  assign stat_o.item_le_pick = (item_q[EntW-1:HANDLE_WIDTH] <= pick[EntW-1:HANDLE_WIDTH]);

  // Result beat.
  assign done_o        = done_q;
  assign out_handle_o  = out_q[HANDLE_WIDTH-1:0];
  assign out_key_o     = out_q[EntW-1:HANDLE_WIDTH];
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = (count_q == '0);
  assign min_key_o     = is_empty_o ? '0 : root_q[EntW-1:HANDLE_WIDTH];

endmodule
`default_nettype wire

>>> rtl/core/bmhq_ctrl.sv
`default_nettype none
module bmhq_ctrl import bmhq_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  input  wire logic       req_type_i,
  output logic            busy,
  output bmhq_cmd_t       cmd_o,
  input  wire bmhq_stat_t stat_i
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INS_RD   = 3'd1;
  localparam logic [2:0] ST_INS_CMP  = 3'd2;
  localparam logic [2:0] ST_EXT_LAST = 3'd3;
  localparam logic [2:0] ST_EXT_LOAD = 3'd4;
  localparam logic [2:0] ST_SD_RDL   = 3'd5;
  localparam logic [2:0] ST_SD_RDR   = 3'd6;
  localparam logic [2:0] ST_SD_CMP   = 3'd7;

  logic [2:0] state_q, state_d;

  assign busy = (state_q != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = RD_PARENT;
    cmd_o.wr_sel = WR_ITEM;
    cmd_o.status = STATUS_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_INSERT) begin
            if (stat_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = STATUS_FULL;
            end else begin
              cmd_o.accept_ins = 1'b1;
              state_d = ST_INS_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = STATUS_EMPTY;
            end else begin
              cmd_o.accept_ext = 1'b1;
              if (stat_i.one) begin
                cmd_o.finish = 1'b1;
              end else begin
                state_d = ST_EXT_LAST;
              end
            end
          end
        end
      end
      // Sift up: fetch the parent of the hole, or settle at the root.
      ST_INS_RD: begin
        if (stat_i.hole_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PARENT;
          state_d = ST_INS_CMP;
        end
      end
      // Move a strictly greater parent down, else place the new entry.
      ST_INS_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.parent_gt) begin
          cmd_o.wr_sel = WR_PARENT;
          state_d = ST_INS_RD;
        end else begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      // Fetch the last entry to sift it down from the root.
      ST_EXT_LAST: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_LAST;
        state_d = ST_EXT_LOAD;
      end
      ST_EXT_LOAD: begin
        cmd_o.load_item = 1'b1;
        state_d = ST_SD_RDL;
      end
      // Sift down: read the left child, or settle at a leaf.
      ST_SD_RDL: begin
        if (stat_i.has_left) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_LEFT;
          state_d = ST_SD_RDR;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SD_RDR: begin
        cmd_o.cap_left = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = RD_RIGHT;
        state_d = ST_SD_CMP;
      end
      // Place the entry, or lift the smaller child into the hole.
      ST_SD_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (stat_i.item_le_pick) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.wr_sel = WR_PICK;
          state_d = ST_SD_RDL;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> test/binary_min_heap_queue_tb.sv
`default_nettype none
module binary_min_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int unsigned CAP = CapacityDef;
  localparam int unsigned KW  = KeyWidthDef;
  localparam int unsigned HW  = HandleWidthDef;
  localparam int unsigned CW  = $clog2(CapacityDef + 1);

  localparam int unsigned MAX_CYCLES  = 1000000;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic          req;
    logic [KW-1:0] key;
    logic [HW-1:0] handle;
  } heap_req_t;

  typedef struct packed {
    logic [HW-1:0]      handle;
    logic [KW-1:0]      key;
    logic [StatusW-1:0] status;
    logic [CW-1:0]      count;
    logic               empty;
    logic [KW-1:0]      min_key;
  } heap_result_t;

  // Clock, reset and block inputs, all known from time zero.
  logic          clk_i      = 1'b0;
  logic          rst_ni     = 1'b0;
  logic          start      = 1'b0;
  logic          req_type_i = 1'b0;
  logic [KW-1:0] key_i      = '0;
  logic [HW-1:0] handle_i   = '0;

  logic               busy;
  logic               done_o;
  logic [HW-1:0]      out_handle_o;
  logic [KW-1:0]      out_key_o;
  logic [StatusW-1:0] status_o;
  logic [CW-1:0]      entry_count_o;
  logic               is_empty_o;
  logic [KW-1:0]      min_key_o;

  binary_min_heap_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .handle_i      (handle_i),
    .done_o        (done_o),
    .out_handle_o  (out_handle_o),
    .out_key_o     (out_key_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .min_key_o     (min_key_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow heap that mirrors the block's entry store.
  logic [KW-1:0] heap_keys    [CAP];
  logic [HW-1:0] heap_handles [CAP];
  int unsigned   heap_fill = 0;

  heap_req_t    request_q [$];
  heap_result_t result_q  [$];

  int unsigned gap_left       = 0;
  bit          idle_mode      = 1'b1;
  bit          beat_taken     = 1'b0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned n_insert       = 0;
  int unsigned n_extract      = 0;
  int unsigned n_full         = 0;
  int unsigned n_empty        = 0;
  int unsigned peak_fill      = 0;

  task automatic swap_entries(input int unsigned a, input int unsigned b);
    logic [KW-1:0] tk;
    logic [HW-1:0] th;
    tk = heap_keys[a];
    th = heap_handles[a];
    heap_keys[a]    = heap_keys[b];
    heap_handles[a] = heap_handles[b];
    heap_keys[b]    = tk;
    heap_handles[b] = th;
  endtask

  // Apply one request to the shadow heap and build the result it should give.
  task automatic heap_apply(input logic req, input logic [KW-1:0] key,
                            input logic [HW-1:0] handle, output heap_result_t res);
    int unsigned i;
    int unsigned parent;
    int unsigned left;
    int unsigned right;
    int unsigned pick;
    res = '0;
    res.status = STATUS_OK;
    if (req == REQ_INSERT) begin
      if (heap_fill >= CAP) begin
        res.status = STATUS_FULL;
      end else begin
        i = heap_fill;
        heap_keys[i]    = key;
        heap_handles[i] = handle;
        heap_fill++;
        // Climb only while the parent is strictly greater.
        while (i > 0) begin
          parent = (i - 1) / 2;
          if (heap_keys[parent] <= heap_keys[i]) break;
          swap_entries(i, parent);
          i = parent;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.key    = heap_keys[0];
        res.handle = heap_handles[0];
        heap_fill--;
        heap_keys[0]    = heap_keys[heap_fill];
        heap_handles[0] = heap_handles[heap_fill];
        // Sink toward the smaller child; ties go to the left child.
        i = 0;
        while (2 * i + 1 < heap_fill) begin
          left  = 2 * i + 1;
          right = 2 * i + 2;
          pick  = left;
          if (right < heap_fill && heap_keys[right] < heap_keys[left]) pick = right;
          if (heap_keys[i] <= heap_keys[pick]) break;
          swap_entries(i, pick);
          i = pick;
        end
      end
    end
    res.count   = heap_fill[CW-1:0];
    res.empty   = (heap_fill == 0);
    res.min_key = (heap_fill == 0) ? '0 : heap_keys[0];
  endtask

  // Keys lean toward the extremes and a small range so that ties are common.
  function automatic logic [KW-1:0] rand_key();
    case ($urandom_range(0, 5))
      0: rand_key = '0;
      1: rand_key = '1;
      2: rand_key = KW'($urandom_range(0, 15));
      3: rand_key = '1 - KW'($urandom_range(0, 15));
      default: rand_key = KW'($urandom);
    endcase
  endfunction

  task automatic add_req(input logic req, input logic [KW-1:0] key,
                         input logic [HW-1:0] handle);
    request_q.push_back('{req: req, key: key, handle: handle});
  endtask

  // Mixed traffic whose insert share swings between high and low.
  task automatic add_mixed(input int unsigned n);
    bit insert_heavy;
    insert_heavy = 1'b1;
    repeat (n) begin
      if ($urandom_range(0, 59) == 0) insert_heavy = !insert_heavy;
      if ($urandom_range(0, 99) < (insert_heavy ? 70 : 35)) begin
        add_req(REQ_INSERT, rand_key(), HW'($urandom));
      end else begin
        add_req(REQ_EXTRACT, KW'($urandom), HW'($urandom));
      end
    end
  endtask

  // Monitor: check each result beat, then predict for a request beat taken now.
  always @(posedge clk_i) begin
    heap_result_t exp_res;
    heap_result_t got_res;
    if (rst_ni) begin
      if (done_o) begin
        got_res = '{handle: out_handle_o, key: out_key_o, status: status_o,
                    count: entry_count_o, empty: is_empty_o, min_key: min_key_o};
        if (result_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result beat: handle=%h key=%h status=%0d count=%0d",
                     out_handle_o, out_key_o, status_o, entry_count_o);
        end else begin
          exp_res = result_q.pop_front();
          checked_count++;
          if (got_res.handle !== exp_res.handle || got_res.key !== exp_res.key ||
              got_res.status !== exp_res.status || got_res.count !== exp_res.count ||
              got_res.empty !== exp_res.empty || got_res.min_key !== exp_res.min_key) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: exp handle=%h key=%h status=%0d count=%0d empty=%0d min=%h",
                       exp_res.handle, exp_res.key, exp_res.status, exp_res.count,
                       exp_res.empty, exp_res.min_key);
              $display("          got handle=%h key=%h status=%0d count=%0d empty=%0d min=%h",
                       got_res.handle, got_res.key, got_res.status, got_res.count,
                       got_res.empty, got_res.min_key);
            end
          end
        end
      end
      beat_taken = start && !busy;
      if (beat_taken) begin
        heap_apply(req_type_i, key_i, handle_i, exp_res);
        result_q.push_back(exp_res);
        if (req_type_i == REQ_INSERT) n_insert++;
        else n_extract++;
        if (exp_res.status == STATUS_FULL) n_full++;
        if (exp_res.status == STATUS_EMPTY) n_empty++;
        if (heap_fill > peak_fill) peak_fill = heap_fill;
      end
    end
  end

  // Driver: hold a beat until it is taken, otherwise idle or present the next one.
  always @(negedge clk_i) begin
    heap_req_t item;
    if (rst_ni && !(start && !beat_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (request_q.size() == 0) begin
        start <= 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0) idle_mode = !idle_mode;
        if (request_q.size() > QUIET_TAIL && idle_mode && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 9);
          start <= 1'b0;
        end else begin
          item = request_q.pop_front();
          start      <= 1'b1;
          req_type_i <= item.req;
          key_i      <= item.key;
          handle_i   <= item.handle;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("binary_min_heap_queue_tb NOT OK");
      $finish;
    end
  end

  initial begin
    // Directed part: empty extracts, extreme keys and handles, ties, deep climbs.
    add_req(REQ_EXTRACT, '1, '1);
    add_req(REQ_INSERT, '0, '0);
    add_req(REQ_INSERT, '1, '1);
    add_req(REQ_INSERT, KW'(32'h0000_0100), HW'(16'h1234));
    add_req(REQ_INSERT, KW'(32'h0000_0100), HW'(16'hABCD));
    add_req(REQ_INSERT, '0, HW'(16'h5555));
    repeat (6) add_req(REQ_EXTRACT, '0, '0);
    add_req(REQ_INSERT, KW'(32'h0000_0500), HW'(16'h0001));
    add_req(REQ_INSERT, KW'(32'h0000_0400), HW'(16'h0002));
    add_req(REQ_INSERT, KW'(32'h0000_0300), HW'(16'h0003));
    add_req(REQ_INSERT, KW'(32'h0000_0200), HW'(16'h0004));
    add_req(REQ_INSERT, KW'(32'h0000_0100), HW'(16'h0005));
    add_req(REQ_INSERT, KW'(32'h0000_0100), HW'(16'h0006));
    repeat (3) add_req(REQ_EXTRACT, '1, '1);

    // Random part: insert-heavy and extract-heavy stretches grow and drain the heap.
    add_mixed(300);
    add_mixed(280);

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (request_q.size() != 0 || start) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Checked %0d results: %0d inserts, %0d extracts, peak fill %0d of %0d.",
             checked_count, n_insert, n_extract, peak_fill, CAP);
    $display("Refused inserts on a full heap: %0d, extracts on an empty heap: %0d.",
             n_full, n_empty);
    if (mismatch_count == 0) begin
      $display("binary_min_heap_queue_tb OK");
    end else begin
      $display("binary_min_heap_queue_tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
